// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers for the RTL that checks itself
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset
`define FSD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check on every clock edge, reset included
`define FSD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== hw/rtl/fsd_pkg.sv =====
`timescale 1ns / 1ps

package fsd_pkg;

    // Frame geometry and error precision
    localparam int LINE_PIXELS     = 606;
    localparam int LINE_COUNT      = 808;
    localparam int WORDS_PER_LINE  = 38;
    localparam int ERROR_FRAC_BITS = 8;

    localparam int COL_W   = $clog2(LINE_PIXELS);
    localparam int ROW_W   = $clog2(LINE_COUNT);
    localparam int ADDR_W  = 15;
    localparam int WORD_W  = 16;
    localparam int PIXEL_W = 24;
    localparam int TDATA_W = 32;

    // Luminance, stored error, working sum, product and saturation input widths
    localparam int LUM_W  = ERROR_FRAC_BITS + 8;
    localparam int ERR_W  = ERROR_FRAC_BITS + 12;
    localparam int VAL_W  = ERR_W + 2;
    localparam int PROD_W = VAL_W + 3;
    localparam int SAT_W  = PROD_W + 1;

    // Luminance scaling from the 8 fraction bits of the weighted sum
    localparam int LUM_SHL = (ERROR_FRAC_BITS >= 8) ? ERROR_FRAC_BITS - 8 : 0;
    localparam int LUM_SHR = (ERROR_FRAC_BITS >= 8) ? 0 : 8 - ERROR_FRAC_BITS;

    localparam logic signed [VAL_W-1:0] THRESHOLD   = VAL_W'(255 << (ERROR_FRAC_BITS - 1));
    localparam logic signed [VAL_W-1:0] WHITE_LEVEL = VAL_W'(255 << ERROR_FRAC_BITS);

    localparam logic signed [SAT_W-1:0] ERR_HI = SAT_W'((1 << (ERR_W - 1)) - 1);
    localparam logic signed [SAT_W-1:0] ERR_LO = ~ERR_HI;

    localparam int FRAME_WORDS = LINE_COUNT * WORDS_PER_LINE;

    // One pixel on its way from the feed stage to the diffusion stage
    typedef struct packed {
        logic [LUM_W-1:0] lum;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             last_col;
        logic             last_row;
    } pix_t;

    // Packer status towards the stage control
    typedef struct packed {
        logic emit;
        logic room;
    } pack_stat_t;

    // Clamp a working value to the stored error range
    function automatic logic signed [ERR_W-1:0] sat_err(input logic signed [SAT_W-1:0] v);
        logic signed [ERR_W-1:0] r;
        if (v > ERR_HI) begin
            r = ERR_HI[ERR_W-1:0];
        end else if (v < ERR_LO) begin
            r = ERR_LO[ERR_W-1:0];
        end else begin
            r = v[ERR_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/fsd_ram.sv =====
`timescale 1ns / 1ps

module fsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read, held while not enabled
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/fsd_feed.sv =====
`timescale 1ns / 1ps

module fsd_feed (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      accept,
    input  logic                      fire,
    input  logic [fsd_pkg::PIXEL_W-1:0] pixel,
    output logic [fsd_pkg::COL_W-1:0] rd_addr,
    output logic                      pix_valid,
    output fsd_pkg::pix_t             pix
);

    logic [fsd_pkg::COL_W-1:0] col_reg, col_next;
    logic [fsd_pkg::ROW_W-1:0] row_reg, row_next;
    logic                      valid_reg, valid_next;
    fsd_pkg::pix_t             pix_reg, pix_next;

    logic        at_last_col;
    logic        at_last_row;
    logic [15:0] wsum;
    logic [31:0] lum_wide;

    // Weighted luminance sum, 8 fraction bits
    always_comb begin
        wsum = (16'(pixel[23:16]) * 16'd77) + (16'(pixel[15:8]) * 16'd150)
             + (16'(pixel[7:0]) * 16'd29);
        lum_wide = ((32'(wsum) << fsd_pkg::LUM_SHL) >> fsd_pkg::LUM_SHR);
    end

    assign at_last_col = (col_reg == fsd_pkg::COL_W'(fsd_pkg::LINE_PIXELS - 1));
    assign at_last_row = (row_reg == fsd_pkg::ROW_W'(fsd_pkg::LINE_COUNT - 1));

    // Advance the raster position and capture the item
    always_comb begin
        col_next   = col_reg;
        row_next   = row_reg;
        valid_next = valid_reg;
        pix_next   = pix_reg;
        if (fire) begin
            valid_next = 1'b0;
        end
        if (accept) begin
            valid_next        = 1'b1;
            pix_next.lum      = lum_wide[fsd_pkg::LUM_W-1:0];
            pix_next.col      = col_reg;
            pix_next.row      = row_reg;
            pix_next.last_col = at_last_col;
            pix_next.last_row = at_last_row;
            if (at_last_col) begin
                col_next = '0;
                row_next = at_last_row ? '0 : row_reg + 1'b1;
            end else begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg   <= '0;
            row_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pix_reg <= pix_next;
    end

    assign rd_addr   = col_reg;
    assign pix_valid = valid_reg;
    assign pix       = pix_reg;

endmodule

// ===== hw/rtl/fsd_diffuse.sv =====
`timescale 1ns / 1ps

module fsd_diffuse (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             fire,
    input  fsd_pkg::pix_t                    pix,
    input  logic signed [fsd_pkg::ERR_W-1:0] line_err,
    output logic                             white,
    output logic                             wr_en,
    output logic [fsd_pkg::COL_W-1:0]        wr_addr,
    output logic signed [fsd_pkg::ERR_W-1:0] wr_data
);

    localparam int EW = fsd_pkg::ERR_W;
    localparam int VW = fsd_pkg::VAL_W;
    localparam int PW = fsd_pkg::PROD_W;
    localparam int SW = fsd_pkg::SAT_W;

    logic signed [EW-1:0] carry_reg, carry_next;
    logic signed [EW-1:0] pend_left_reg, pend_left_next;
    logic signed [EW-1:0] pend_center_reg, pend_center_next;
    logic signed [EW-1:0] tail_reg, tail_next;

    logic signed [VW-1:0] below_term;
    logic signed [VW-1:0] val;
    logic signed [VW-1:0] err;
    logic signed [PW-1:0] err_ext;
    logic signed [PW-1:0] share7, share5, share3, share1;
    logic signed [EW-1:0] left_new;
    logic signed [EW-1:0] below_done;

    // Sum the pixel with the diffused error and decide
    always_comb begin
        below_term = (pix.row != '0) ? VW'(line_err) : '0;
        val   = $signed(VW'(pix.lum)) + VW'(carry_reg) + below_term;
        white = (val > fsd_pkg::THRESHOLD);
        err   = white ? val - fsd_pkg::WHITE_LEVEL : val;
    end

    // Floored sixteenths of the error
    always_comb begin
        err_ext = PW'(err);
        share7  = ((err_ext <<< 3) - err_ext) >>> 4;
        share5  = ((err_ext <<< 2) + err_ext) >>> 4;
        share3  = ((err_ext <<< 1) + err_ext) >>> 4;
        share1  = err_ext >>> 4;
        below_done = fsd_pkg::sat_err(SW'(pend_left_reg) + SW'(share3));
        left_new   = fsd_pkg::sat_err(SW'(pend_center_reg) + SW'(share5));
    end

    // Line buffer write: lower-left neighbour, or the deferred line end entry
    always_comb begin
        wr_en = fire;
        if (pix.col == '0) begin
            wr_addr = fsd_pkg::COL_W'(fsd_pkg::LINE_PIXELS - 1);
            wr_data = tail_reg;
        end else begin
            wr_addr = pix.col - 1'b1;
            wr_data = below_done;
        end
    end

    // Update carries and pending sums
    always_comb begin
        carry_next       = carry_reg;
        pend_left_next   = pend_left_reg;
        pend_center_next = pend_center_reg;
        tail_next        = tail_reg;
        if (fire) begin
            if (pix.last_col) begin
                carry_next       = '0;
                pend_left_next   = '0;
                pend_center_next = '0;
                tail_next        = left_new;
            end else begin
                carry_next       = fsd_pkg::sat_err(SW'(share7));
                pend_left_next   = left_new;
                pend_center_next = fsd_pkg::sat_err(SW'(share1));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            carry_reg       <= '0;
            pend_left_reg   <= '0;
            pend_center_reg <= '0;
            tail_reg        <= '0;
        end else begin
            carry_reg       <= carry_next;
            pend_left_reg   <= pend_left_next;
            pend_center_reg <= pend_center_next;
            tail_reg        <= tail_next;
        end
    end

endmodule

// ===== hw/rtl/fsd_pack.sv =====
`timescale 1ns / 1ps

module fsd_pack (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        pix_valid,
    input  logic                        fire,
    input  fsd_pkg::pix_t               pix,
    input  logic                        white,
    input  logic                        m_tready,
    output fsd_pkg::pack_stat_t         stat,
    output logic                        m_tvalid,
    output logic [fsd_pkg::TDATA_W-1:0] m_tdata,
    output logic                        m_tlast
);

    localparam int WW = fsd_pkg::WORD_W;
    localparam int AW = fsd_pkg::ADDR_W;

    logic [WW-1:0] shift_reg, shift_next;
    logic          out_valid_reg, out_valid_next;
    logic [WW-1:0] bits_reg, bits_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic          end_reg, end_next;

    logic [3:0]    slot;
    logic          emit;
    logic [WW-1:0] shifted;
    logic [31:0]   addr_full;

    assign slot = pix.col[3:0];
    assign emit = pix_valid && ((slot == 4'd15) || pix.last_col);

    // Gather pixels and compute the word address
    always_comb begin
        shifted   = {shift_reg[WW-2:0], white};
        addr_full = 32'(pix.row) * 32'(fsd_pkg::WORDS_PER_LINE) + 32'(pix.col >> 4);
    end

    // Load the output register, drop it once taken
    always_comb begin
        shift_next     = shift_reg;
        out_valid_next = out_valid_reg;
        bits_next      = bits_reg;
        addr_next      = addr_reg;
        end_next       = end_reg;
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end
        if (fire) begin
            shift_next = shifted;
            if (emit) begin
                shift_next     = '0;
                out_valid_next = 1'b1;
                bits_next      = shifted << (4'd15 - slot);
                addr_next      = addr_full[AW-1:0];
                end_next       = pix.last_col && pix.last_row;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            shift_reg     <= shift_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        bits_reg <= bits_next;
        addr_reg <= addr_next;
        end_reg  <= end_next;
    end

    assign stat.emit = emit;
    assign stat.room = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(fsd_pkg::TDATA_W - WW - AW){1'b0}}, addr_reg, bits_reg};
    assign m_tlast  = end_reg;

endmodule

// ===== hw/rtl/floyd_steinberg_bitmap_dither.sv =====
`timescale 1ns / 1ps
// Channel   Dir  Fields (lowest bit up)                          Marker
// s_        in   tdata: pixel_color[23:0]                        -
// m_        out  tdata: word_bits[15:0], word_address[30:16]     tlast: frame_end
//
// One pixel is taken every cycle while s_tready is high; a word enters the output
// register when its last pixel fires from the feed register. The line buffer read is
// issued on acceptance, the neighbouring entries are written when that pixel fires.
// s_tready falls only when a word completes while the previous word still waits.
// Reset clears the position, the carries and the output valid; the line buffer
// needs no clearing pass, since row 0 ignores the data it reads.

`include "assert_macros.svh"

module floyd_steinberg_bitmap_dither (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [fsd_pkg::PIXEL_W-1:0]   s_tdata,   // pixel_color[23:0]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [fsd_pkg::TDATA_W-1:0]   m_tdata,   // word_bits[15:0], word_address[30:16]
    output logic                          m_tlast
);

    logic                             accept;
    logic                             fire;
    logic [fsd_pkg::COL_W-1:0]        rd_addr;
    logic                             pix_valid;
    fsd_pkg::pix_t                    pix;
    logic signed [fsd_pkg::ERR_W-1:0] line_err;
    logic                             white;
    logic                             wr_en;
    logic [fsd_pkg::COL_W-1:0]        wr_addr;
    logic signed [fsd_pkg::ERR_W-1:0] wr_data;
    fsd_pkg::pack_stat_t              stat;

    // Stage control: diffusion stalls only when a completed word meets a full output register
    assign fire     = pix_valid && (!stat.emit || stat.room);
    assign s_tready = !pix_valid || fire;
    assign accept   = s_tvalid && s_tready;

    fsd_feed u_feed (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .fire      (fire),
        .pixel     (s_tdata),
        .rd_addr   (rd_addr),
        .pix_valid (pix_valid),
        .pix       (pix)
    );

    fsd_ram #(
        .WIDTH (fsd_pkg::ERR_W),
        .DEPTH (fsd_pkg::LINE_PIXELS)
    ) u_line (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (line_err)
    );

    fsd_diffuse u_diffuse (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .fire     (fire),
        .pix      (pix),
        .line_err (line_err),
        .white    (white),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data)
    );

    fsd_pack u_pack (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pix_valid (pix_valid),
        .fire      (fire),
        .pix       (pix),
        .white     (white),
        .m_tready  (m_tready),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // Line buffer write never lands on the entry being read
    `FSD_ASSERT(a_no_rw_clash, (wr_en && accept) |-> (wr_addr != rd_addr), "line buffer read-write clash")
    // Frame end word carries the last word address
    `FSD_ASSERT(a_frame_end_addr, (m_tvalid && m_tlast) |-> (m_tdata[30:16] == fsd_pkg::ADDR_W'(fsd_pkg::FRAME_WORDS - 1)), "frame end on wrong address")
    // Input backpressure only from a waiting word
    `FSD_ASSERT(a_stall_cause, !s_tready |-> (m_tvalid && !m_tready), "input stalled without output backpressure")

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    localparam int LINE_PIXELS    = fsd_pkg::LINE_PIXELS;
    localparam int LINE_COUNT     = fsd_pkg::LINE_COUNT;
    localparam int WORDS_PER_LINE = fsd_pkg::WORDS_PER_LINE;
    localparam int FRAC           = fsd_pkg::ERROR_FRAC_BITS;
    localparam int ERR_MAX        = (1 << (FRAC + 11)) - 1;
    localparam int ERR_MIN        = -ERR_MAX - 1;

    // One full line and part of the next, so the line buffer is read back
    localparam int TOTAL_PIXELS = 900;

    localparam int HOLD_AT     = 150;
    localparam int HOLD_CYCLES = 600;
    localparam int PAUSE_AT    = 350;
    localparam int QUIET_FROM  = 500;
    localparam int QUIET_TO    = 800;
    localparam int DRAIN       = 20;
    localparam int STUCK_LIMIT = 5000;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tlast;

    bit idle_on       = 1'b1;
    int hold_requests = 0;
    int holds_done    = 0;
    int hold_left     = 0;

    typedef struct packed {
        logic [15:0] bits;
        logic [14:0] addr;
        logic        fend;
    } dither_word_t;

    // Error-diffusion predictor and the queue of words it expects
    class dither_scoreboard;
        int           below_err [LINE_PIXELS];
        int           right_carry;
        int           pend_left;
        int           pend_centre;
        logic [15:0]  word_acc;
        int           col;
        int           row;
        dither_word_t word_q [$];
        int           mismatches;

        function int clamp_err(int v);
            if (v > ERR_MAX) return ERR_MAX;
            if (v < ERR_MIN) return ERR_MIN;
            return v;
        endfunction

        function int pending();
            return word_q.size();
        endfunction

        // Advance the dither by one pixel and queue the word it completes
        function void note_pixel(logic [23:0] pix);
            int           lum;
            int           val;
            int           err;
            int           x;
            int           y;
            int           slot;
            bit           last_col;
            bit           white;
            dither_word_t w;
            lum = 77 * int'(pix[23:16]) + 150 * int'(pix[15:8]) + 29 * int'(pix[7:0]);
            if (FRAC >= 8) begin
                lum = lum <<< (FRAC - 8);
            end else begin
                lum = lum >>> (8 - FRAC);
            end
            x = col;
            y = row;
            last_col = (x + 1 >= LINE_PIXELS);

            // Row 0 takes no error from above
            val = lum + right_carry;
            if (y > 0) begin
                val = val + below_err[x];
            end
            white = (val > (255 <<< (FRAC - 1)));
            err = white ? val - (255 <<< FRAC) : val;

            // Spread the error, flooring each share on its own
            right_carry = last_col ? 0 : clamp_err((err * 7) >>> 4);
            if (x >= 1) begin
                below_err[x - 1] = clamp_err(pend_left + ((err * 3) >>> 4));
            end
            pend_left = clamp_err(pend_centre + ((err * 5) >>> 4));
            pend_centre = last_col ? 0 : clamp_err(err >>> 4);
            if (last_col) begin
                below_err[x] = pend_left;
                pend_left = 0;
                pend_centre = 0;
            end

            // Pack MSB first; a short last word is left-aligned
            word_acc = {word_acc[14:0], white};
            slot = x % 16;
            if (slot == 15 || last_col) begin
                w.bits = word_acc << (15 - slot);
                w.addr = 15'(y * WORDS_PER_LINE + x / 16);
                w.fend = last_col && (y + 1 >= LINE_COUNT);
                word_q.push_back(w);
                word_acc = '0;
                if (last_col) begin
                    col = 0;
                    row = w.fend ? 0 : y + 1;
                end else begin
                    col = x + 1;
                end
            end else begin
                col = x + 1;
            end
        endfunction

        // Compare one output word with the oldest expectation
        function void check_word(logic [31:0] tdata, logic tlast);
            dither_word_t w;
            if (word_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected word: bits %h addr %0d last %b",
                             tdata[15:0], tdata[30:16], tlast);
                end
            end else begin
                w = word_q.pop_front();
                if (tdata[15:0] !== w.bits || tdata[30:16] !== w.addr ||
                        tlast !== w.fend || tdata[31] !== 1'b0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display({"word mismatch: expected bits %h addr %0d last %b, ",
                                  "got bits %h addr %0d last %b pad %b"},
                                 w.bits, w.addr, w.fend, tdata[15:0], tdata[30:16],
                                 tlast, tdata[31]);
                    end
                end
            end
        endfunction
    endclass

    dither_scoreboard dither_sb = new;

    floyd_steinberg_bitmap_dither i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // Clock
    initial begin
        forever begin
            #5 aclk = ~aclk;
        end
    end

    // Offer one pixel, idling at random first, and hold it until accepted
    task automatic send_pixel(input logic [23:0] pix);
        while (idle_on && $urandom_range(99) < 33) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        do begin
            @(posedge aclk);
        end while (!s_tready);
    endtask

    // Random content: half full colour, the rest greys around the threshold, flat extremes and random greys
    function automatic logic [23:0] next_pixel();
        logic [7:0] g;
        case ($urandom_range(9))
            0, 1, 2, 3, 4: begin
                return 24'($urandom);
            end
            5, 6: begin
                g = 8'($urandom_range(136, 120));
                return {g, g, g};
            end
            7: begin
                return $urandom_range(1) ? 24'hFFFFFF : 24'h000000;
            end
            default: begin
                g = 8'($urandom);
                return {g, g, g};
            end
        endcase
    endfunction

    // Result side: random stalls, plus a long hold-off on request
    always @(posedge aclk) begin
        if (holds_done != hold_requests) begin
            holds_done = holds_done + 1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= !(idle_on && $urandom_range(99) < 33);
        end
    end

    // Note accepted pixels and check accepted words
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                dither_sb.note_pixel(s_tdata);
            end
            if (m_tvalid && m_tready) begin
                dither_sb.check_word(m_tdata, m_tlast);
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    initial begin
        int stuck;
        stuck = 0;
        while (stuck < STUCK_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                stuck = 0;
            end else begin
                stuck = stuck + 1;
            end
        end
        $display("floyd_steinberg_bitmap_dither test failed");
        $finish;
    end

    // Stimulus
    initial begin
        logic [23:0] corner_pixels [$] = '{
            24'h000000, 24'hFFFFFF, 24'h7F7F7F, 24'h808080, 24'hFF0000,
            24'h00FF00, 24'h0000FF, 24'h800000, 24'h008000, 24'h000080,
            24'h010101, 24'hFEFEFE, 24'h7F8080, 24'h807F7F, 24'hAAAAAA,
            24'h555555, 24'h000000, 24'hFFFFFF, 24'hFFFFFF, 24'h000000
        };
        int sent;
        sent = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Extremes, primaries and greys either side of the threshold at the frame start
        foreach (corner_pixels[i]) begin
            send_pixel(corner_pixels[i]);
            sent++;
        end

        // Rest of the first line and into the second
        while (sent < TOTAL_PIXELS) begin
            if (sent == HOLD_AT) begin
                hold_requests = hold_requests + 1;
            end
            if (sent == PAUSE_AT) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
                while (dither_sb.pending() != 0) @(posedge aclk);
            end
            if (sent == QUIET_FROM) begin
                idle_on = 1'b0;
            end
            if (sent == QUIET_TO) begin
                idle_on = 1'b1;
            end
            send_pixel(next_pixel());
            sent++;
        end
        s_tvalid <= 1'b0;

        // Drain the remaining words
        while (dither_sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
        if (dither_sb.mismatches == 0) begin
            $display("floyd_steinberg_bitmap_dither test passed");
        end else begin
            $display("floyd_steinberg_bitmap_dither test failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/fsd_pkg.sv
hw/rtl/fsd_ram.sv
hw/rtl/fsd_feed.sv
hw/rtl/fsd_diffuse.sv
hw/rtl/fsd_pack.sv
hw/rtl/floyd_steinberg_bitmap_dither.sv
test/testbench.sv
